// ----- rtl/pfdr_pkg.sv -----
package pfdr_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int SRC_W  = 16;
  localparam int DST_W  = 16;
  localparam int TS_W   = 32;
  localparam int CAP_W  = 9;
  localparam int CNT_W  = 9;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FWD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CNT = 2'd2;

  typedef struct packed {
    logic load;    // capture the accepted transaction
    logic issue;   // read one ring entry
    logic write;   // append the new packet unless it is a duplicate
    logic finish;  // load the output register, pop on forward
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_done;
    logic             occ_zero;
    logic             out_free;
    logic [OCC_W-1:0] occ;
  } dp_status_t;

endpackage

// ----- rtl/pfdr_if.sv -----
interface pfdr_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfdr_pkg::CMD_W-1:0] command;
  logic [pfdr_pkg::SRC_W-1:0] in_source;
  logic [pfdr_pkg::DST_W-1:0] destination;
  logic [pfdr_pkg::TS_W-1:0]  timestamp;
  logic [pfdr_pkg::TS_W-1:0]  start_time;
  logic [pfdr_pkg::TS_W-1:0]  end_time;

  modport source (output valid, command, in_source, destination, timestamp, start_time,
                  end_time, input ready);
  modport sink (input valid, command, in_source, destination, timestamp, start_time,
                end_time, output ready);
endinterface

interface pfdr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic                       packet_valid;
  logic [pfdr_pkg::SRC_W-1:0] out_source;
  logic [pfdr_pkg::DST_W-1:0] out_destination;
  logic [pfdr_pkg::TS_W-1:0]  out_timestamp;
  logic [pfdr_pkg::CNT_W-1:0] match_count;

  modport source (output valid, accepted, packet_valid, out_source, out_destination,
                  out_timestamp, match_count, input ready);
  modport sink (input valid, accepted, packet_valid, out_source, out_destination,
                out_timestamp, match_count, output ready);
endinterface

// ----- rtl/pfdr_ctrl.sv -----
module pfdr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfdr_pkg::dp_status_t status,
  output pfdr_pkg::ctrl_cmd_t  cmd
);
  import pfdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_WRITE,
    ST_FWD_RD,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_ADD, CMD_CNT: state_nxt = ST_SCAN;
          CMD_FWD:          state_nxt = status.occ_zero ? ST_RESULT : ST_FWD_RD;
          default:          state_nxt = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        // last compare lands on the same edge that leaves this state
        if (status.scan_done) begin
          state_nxt = (status.cmd == CMD_ADD) ? ST_WRITE : ST_RESULT;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_FWD_RD: begin
        cmd.issue = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pfdr_dp.sv -----
module pfdr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfdr_pkg::CAP_W-1:0]      cfg_wdata,
  input  logic [pfdr_pkg::CMD_W-1:0]      in_command,
  input  logic [pfdr_pkg::SRC_W-1:0]      in_source,
  input  logic [pfdr_pkg::DST_W-1:0]      in_destination,
  input  logic [pfdr_pkg::TS_W-1:0]       in_timestamp,
  input  logic [pfdr_pkg::TS_W-1:0]       in_start_time,
  input  logic [pfdr_pkg::TS_W-1:0]       in_end_time,
  input  pfdr_pkg::ctrl_cmd_t             cmd,
  output pfdr_pkg::dp_status_t            status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic                            out_packet_valid,
  output logic [pfdr_pkg::SRC_W-1:0]      out_source,
  output logic [pfdr_pkg::DST_W-1:0]      out_destination,
  output logic [pfdr_pkg::TS_W-1:0]       out_timestamp,
  output logic [pfdr_pkg::CNT_W-1:0]      out_match_count
);
  import pfdr_pkg::*;

  localparam int ENT_W = SRC_W + DST_W + TS_W;
  localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

  logic [ENT_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_r;
  logic [ADDR_W-1:0] head_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  k_r;
  logic              pend_r;
  logic              dup_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ENT_W-1:0]  rd_data_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [SRC_W-1:0]  src_r;
  logic [DST_W-1:0]  dst_r;
  logic [TS_W-1:0]   ts_r;
  logic [TS_W-1:0]   lo_r;
  logic [TS_W-1:0]   hi_r;

  logic              out_valid_r;
  logic              out_acc_r;
  logic              out_pv_r;
  logic [SRC_W-1:0]  out_src_r;
  logic [DST_W-1:0]  out_dst_r;
  logic [TS_W-1:0]   out_ts_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [OCC_W-1:0]  eff_cap;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_slot;
  logic              do_write;
  logic              do_pop;
  logic              fwd_hit;
  logic [SRC_W-1:0]  rd_src;
  logic [DST_W-1:0]  rd_dst;
  logic [TS_W-1:0]   rd_ts;

  assign {rd_src, rd_dst, rd_ts} = rd_data_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (OCC_W'(cap_r) > DEPTH_OCC) begin
      eff_cap = DEPTH_OCC;
    end else begin
      eff_cap = OCC_W'(cap_r);
    end
  end

  assign rd_addr  = head_r + k_r[ADDR_W-1:0];
  // append slot is head + occupancy, with or without eviction
  assign wr_slot  = head_r + occ_r[ADDR_W-1:0];
  assign do_write = cmd.write && !dup_r;
  assign fwd_hit  = (cmd_r == CMD_FWD) && (occ_r != '0);
  assign do_pop   = cmd.finish && fwd_hit;

  assign status.cmd       = cmd_r;
  assign status.scan_done = (k_r == occ_r);
  assign status.occ_zero  = (occ_r == '0);
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.occ       = occ_r;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_slot] <= {src_r, dst_r, ts_r};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      src_r <= in_source;
      dst_r <= in_destination;
      ts_r  <= in_timestamp;
      lo_r  <= in_start_time;
      hi_r  <= in_end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_W'(DEPTH);
      head_r <= '0;
      occ_r  <= '0;
      k_r    <= '0;
      pend_r <= 1'b0;
      dup_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      pend_r <= cmd.issue;
      if (cmd.load) begin
        k_r   <= '0;
        dup_r <= 1'b0;
        cnt_r <= '0;
      end else begin
        if (cmd.issue) begin
          k_r <= k_r + OCC_W'(1);
        end
        if (pend_r) begin
          if (rd_src == src_r && rd_dst == dst_r && rd_ts == ts_r) begin
            dup_r <= 1'b1;
          end
          if (rd_dst == dst_r && rd_ts >= lo_r && rd_ts <= hi_r) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      if (do_write) begin
        if (occ_r >= eff_cap) begin
          // drop the oldest entries down to capacity - 1, then append
          head_r <= head_r + ADDR_W'(occ_r - eff_cap + OCC_W'(1));
          occ_r  <= eff_cap;
        end else begin
          occ_r <= occ_r + OCC_W'(1);
        end
      end else if (do_pop) begin
        head_r <= head_r + ADDR_W'(1);
        occ_r  <= occ_r - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_acc_r <= (cmd_r == CMD_ADD) && !dup_r;
      out_pv_r  <= fwd_hit;
      out_src_r <= fwd_hit ? rd_src : '0;
      out_dst_r <= fwd_hit ? rd_dst : '0;
      out_ts_r  <= fwd_hit ? rd_ts : '0;
      out_cnt_r <= (cmd_r == CMD_CNT) ? cnt_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_packet_valid = out_pv_r;
  assign out_source       = out_src_r;
  assign out_destination  = out_dst_r;
  assign out_timestamp    = out_ts_r;
  assign out_match_count  = out_cnt_r;

endmodule

// ----- rtl/packet_fifo_dedup_range_count_top.sv -----
// Scans read one ring entry a cycle. One transaction in work at a time: the next is
// accepted the cycle after the result is loaded.
// Reset clears pointers, occupancy, capacity (to 256) and the output valid;
// the packet store is not cleared, only live entries are ever read.
module packet_fifo_dedup_range_count_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pfdr_pkg::CAP_W-1:0] cfg_wdata,
  pfdr_in_if.sink                    in_chan,
  pfdr_out_if.source                 out_chan
);
  import pfdr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pfdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfdr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_chan.command),
    .in_source        (in_chan.in_source),
    .in_destination   (in_chan.destination),
    .in_timestamp     (in_chan.timestamp),
    .in_start_time    (in_chan.start_time),
    .in_end_time      (in_chan.end_time),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_accepted     (out_chan.accepted),
    .out_packet_valid (out_chan.packet_valid),
    .out_source       (out_chan.out_source),
    .out_destination  (out_chan.out_destination),
    .out_timestamp    (out_chan.out_timestamp),
    .out_match_count  (out_chan.match_count)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.occ <= OCC_W'(DEPTH))
    else $error("occupancy above ring depth");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("transaction accepted while another is in work");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.write && cmd.issue))
    else $error("ring write and scan read in the same cycle");

endmodule
